>>> src/b64c_pkg.sv
`timescale 1ns / 1ps

package b64c_pkg;

  localparam logic       MODE_ENCODE = 1'b0;
  localparam logic       MODE_DECODE = 1'b1;
  localparam logic [7:0] PAD_CHAR    = 8'h3D;
  localparam int         MAX_RESULTS = 4;
  localparam int         CNT_W       = $clog2(MAX_RESULTS + 1);

  // One result item
  typedef struct packed {
    logic [7:0] data;
    logic       has_data;
    logic       bad_char;
    logic       last;
  } result_t;

  // Message state carried between items
  typedef struct packed {
    logic [1:0] group_pos;
    logic [5:0] leftover;
    logic       pad_seen;
  } codec_state_t;

  localparam codec_state_t STATE_CLEAR = '{group_pos: 2'd0, leftover: 6'd0, pad_seen: 1'b0};
  localparam result_t      RESULT_NONE = '{data: 8'd0, has_data: 1'b0, bad_char: 1'b0,
                                           last: 1'b0};

  // 6-bit value to alphabet character
  function automatic logic [7:0] to_char(input logic [5:0] v);
    logic [7:0] w;
    w = {2'b00, v};
    if (v < 6'd26)      to_char = 8'h41 + w;
    else if (v < 6'd52) to_char = 8'h61 + w - 8'd26;
    else if (v < 6'd62) to_char = 8'h30 + w - 8'd52;
    else if (v == 6'd62) to_char = 8'h2B;
    else                 to_char = 8'h2F;
  endfunction

  // Alphabet character to {valid, 6-bit value}
  function automatic logic [6:0] from_char(input logic [7:0] c);
    logic [7:0] w;
    w = 8'd0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      w = c - 8'h41;
      from_char = {1'b1, w[5:0]};
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      w = c - 8'h61 + 8'd26;
      from_char = {1'b1, w[5:0]};
    end else if (c >= 8'h30 && c <= 8'h39) begin
      w = c - 8'h30 + 8'd52;
      from_char = {1'b1, w[5:0]};
    end else if (c == 8'h2B) begin
      from_char = {1'b1, 6'd62};
    end else if (c == 8'h2F) begin
      from_char = {1'b1, 6'd63};
    end else begin
      from_char = 7'd0;
    end
  endfunction

endpackage

>>> src/base64_codec_unit.sv
`timescale 1ns / 1ps

// Streaming base64 codec (standard alphabet, '=' padding).
// cfg_valid/cfg_ready/cfg_data writes the mode bit (0 encode, 1 decode);
// any write also clears the message state. Write only while idle.
// s_axis carries one byte or character per transfer, tlast on the
// message's final item. m_axis returns result items: tdata is the
// character or byte, tuser[0] has_data, tuser[1] bad_char, tlast ends
// the message.
// Each input item yields 0 to 4 results (encode: 1 or 2, up to 4 on a
// last byte with padding; decode: 1 or none). They are computed in the
// accept cycle and held in a four-entry result buffer that drains one
// result per cycle while m_axis_tready is high, so the first result
// appears in the cycle after the input transfer. A new item is accepted
// in the cycle the buffer's final result leaves, so the codec takes the
// next item while its last result is still going out.
// When m_axis_tready is low a non-empty buffer holds and s_axis_tready
// drops. Reset selects encode mode, clears the message state and empties
// the buffer.
module base64_codec_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data,          // mode
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,      // [7:0] in_byte
  input  logic       s_axis_tlast,      // in_last
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,      // [7:0] out_byte
  output logic [1:0] m_axis_tuser,      // [0] has_data, [1] bad_char
  output logic       m_axis_tlast       // out_last
);
  import b64c_pkg::*;

  logic               mode;
  codec_state_t       state;
  codec_state_t       state_next;
  result_t            res_buf [MAX_RESULTS];
  result_t            step_res [MAX_RESULTS];
  logic [CNT_W-1:0]   cnt;
  logic [CNT_W-1:0]   step_cnt;
  logic               in_xfer;
  logic               out_xfer;

  b64c_step u_step (
    .mode       (mode),
    .state      (state),
    .in_byte    (s_axis_tdata),
    .in_last    (s_axis_tlast),
    .res        (step_res),
    .res_cnt    (step_cnt),
    .state_next (state_next)
  );

  // handshakes
  assign cfg_ready     = 1'b1;
  assign out_xfer      = m_axis_tvalid && m_axis_tready;
  assign s_axis_tready = (cnt == '0) || ((cnt == CNT_W'(1)) && m_axis_tready);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  assign m_axis_tvalid = (cnt != '0);
  assign m_axis_tdata  = res_buf[0].data;
  assign m_axis_tuser  = {res_buf[0].bad_char, res_buf[0].has_data};
  assign m_axis_tlast  = res_buf[0].last;

  // control: mode, message state, fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= MODE_ENCODE;
      state <= STATE_CLEAR;
      cnt   <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        mode  <= cfg_data;
        state <= STATE_CLEAR;
      end else if (in_xfer) begin
        state <= state_next;
      end
      if (in_xfer)       cnt <= step_cnt;
      else if (out_xfer) cnt <= cnt - CNT_W'(1);
    end
  end

  // result buffer: load on input transfer, shift down on output transfer
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      for (int i = 0; i < MAX_RESULTS; i++) begin
        res_buf[i] <= step_res[i];
      end
    end else if (out_xfer) begin
      for (int i = 0; i < MAX_RESULTS - 1; i++) begin
        res_buf[i] <= res_buf[i + 1];
      end
      res_buf[MAX_RESULTS - 1] <= RESULT_NONE;
    end
  end

endmodule

>>> src/b64c_step.sv
`timescale 1ns / 1ps

// Per-item codec step: results of one input item and the next message state
module b64c_step (
  input  logic                   mode,
  input  b64c_pkg::codec_state_t state,
  input  logic [7:0]             in_byte,
  input  logic                   in_last,
  output b64c_pkg::result_t      res [b64c_pkg::MAX_RESULTS],
  output logic [b64c_pkg::CNT_W-1:0] res_cnt,
  output b64c_pkg::codec_state_t state_next
);
  import b64c_pkg::*;

  logic [6:0] dec_val;
  logic [5:0] lo_next;
  logic [1:0] pos_next;

  assign dec_val = from_char(in_byte);

  always_comb begin
    for (int i = 0; i < MAX_RESULTS; i++) begin
      res[i] = RESULT_NONE;
    end
    res_cnt    = '0;
    state_next = state;
    lo_next    = state.leftover;
    pos_next   = state.group_pos;

    if (mode == MODE_ENCODE) begin
      // one or two characters from the byte
      case (state.group_pos)
        2'd0: begin
          res[0]   = '{data: to_char(in_byte[7:2]), has_data: 1'b1, bad_char: 1'b0, last: 1'b0};
          lo_next  = {in_byte[1:0], 4'd0};
          pos_next = 2'd1;
          res_cnt  = CNT_W'(1);
        end
        2'd1: begin
          res[0]   = '{data: to_char({state.leftover[5:4], in_byte[7:4]}), has_data: 1'b1,
                       bad_char: 1'b0, last: 1'b0};
          lo_next  = {in_byte[3:0], 2'd0};
          pos_next = 2'd2;
          res_cnt  = CNT_W'(1);
        end
        default: begin
          res[0]   = '{data: to_char({state.leftover[5:2], in_byte[7:6]}), has_data: 1'b1,
                       bad_char: 1'b0, last: 1'b0};
          res[1]   = '{data: to_char(in_byte[5:0]), has_data: 1'b1, bad_char: 1'b0,
                       last: 1'b0};
          lo_next  = 6'd0;
          pos_next = 2'd0;
          res_cnt  = CNT_W'(2);
        end
      endcase
      state_next.leftover  = lo_next;
      state_next.group_pos = pos_next;

      // flush and pad at end of message
      if (in_last) begin
        case (pos_next)
          2'd1: begin
            res[1]  = '{data: to_char(lo_next), has_data: 1'b1, bad_char: 1'b0, last: 1'b0};
            res[2]  = '{data: PAD_CHAR, has_data: 1'b1, bad_char: 1'b0, last: 1'b0};
            res[3]  = '{data: PAD_CHAR, has_data: 1'b1, bad_char: 1'b0, last: 1'b1};
            res_cnt = CNT_W'(4);
          end
          2'd2: begin
            res[1]  = '{data: to_char(lo_next), has_data: 1'b1, bad_char: 1'b0, last: 1'b0};
            res[2]  = '{data: PAD_CHAR, has_data: 1'b1, bad_char: 1'b0, last: 1'b1};
            res_cnt = CNT_W'(3);
          end
          default: begin
            if (res_cnt == CNT_W'(2)) res[1].last = 1'b1;
            else                      res[0].last = 1'b1;
          end
        endcase
        state_next = STATE_CLEAR;
      end
    end else begin
      // decode: at most one result
      if (!state.pad_seen) begin
        if (in_byte == PAD_CHAR) begin
          state_next.pad_seen = 1'b1;
        end else if (!dec_val[6]) begin
          res[0]  = '{data: 8'd0, has_data: 1'b0, bad_char: 1'b1, last: 1'b0};
          res_cnt = CNT_W'(1);
        end else begin
          case (state.group_pos)
            2'd0: begin
              state_next.leftover  = dec_val[5:0];
              state_next.group_pos = 2'd1;
            end
            2'd1: begin
              res[0] = '{data: {state.leftover, dec_val[5:4]}, has_data: 1'b1,
                         bad_char: 1'b0, last: 1'b0};
              res_cnt = CNT_W'(1);
              state_next.leftover  = {2'd0, dec_val[3:0]};
              state_next.group_pos = 2'd2;
            end
            2'd2: begin
              res[0] = '{data: {state.leftover[3:0], dec_val[5:2]}, has_data: 1'b1,
                         bad_char: 1'b0, last: 1'b0};
              res_cnt = CNT_W'(1);
              state_next.leftover  = {4'd0, dec_val[1:0]};
              state_next.group_pos = 2'd3;
            end
            default: begin
              res[0] = '{data: {state.leftover[1:0], dec_val[5:0]}, has_data: 1'b1,
                         bad_char: 1'b0, last: 1'b0};
              res_cnt = CNT_W'(1);
              state_next.leftover  = 6'd0;
              state_next.group_pos = 2'd0;
            end
          endcase
        end
      end
      // end of message: empty marker when nothing came out
      if (in_last) begin
        res[0].last = 1'b1;
        res_cnt     = CNT_W'(1);
        state_next  = STATE_CLEAR;
      end
    end
  end

endmodule
